FILE: hw/rtl/positional_list_buffer_unit_assert.svh
// Assertion macros for the positional list buffer.
// Expects clk and rst_n in scope at the place of use.
`ifndef POSITIONAL_LIST_BUFFER_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_BUFFER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PLBU_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("plbu assertion failed");
`define PLBU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plbu assertion failed");
`else
`define PLBU_ASSERT(label, prop)
`define PLBU_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/plbu_pkg.sv
// Shared types and constants for the positional list buffer.
// No dependencies.
`timescale 1ns / 1ps

package plbu_pkg;

    localparam int CAPACITY_DEF = 16;
    // index field sized for the largest supported capacity (256)
    localparam int IDX_MAX_W    = 8;
    localparam int DATA_W       = 32;

    typedef enum logic [2:0] {
        REQ_INS_FIRST = 3'd0,
        REQ_INS_LAST  = 3'd1,
        REQ_INS_AT    = 3'd2,
        REQ_DEL_FIRST = 3'd3,
        REQ_DEL_LAST  = 3'd4,
        REQ_DEL_AT    = 3'd5,
        REQ_READ      = 3'd6
    } req_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } status_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic                 ins_en;
        logic                 del_en;
        logic                 rd_en;
        logic [IDX_MAX_W-1:0] idx;
        logic [DATA_W-1:0]    value;
    } plbu_cmd_t;

endpackage

FILE: hw/rtl/plbu_cell.sv
// One storage cell of the list chain: holds one entry, shifts from a neighbour.
// Depends on plbu_pkg.
`timescale 1ns / 1ps

module plbu_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                           clk,
    input  plbu_pkg::plbu_cmd_t            cmd,
    input  logic [plbu_pkg::DATA_W-1:0]    left,
    input  logic [plbu_pkg::DATA_W-1:0]    right,
    output logic [plbu_pkg::DATA_W-1:0]    entry,
    output logic [plbu_pkg::DATA_W-1:0]    rd_data
);
    import plbu_pkg::*;

    localparam logic [IDX_MAX_W-1:0] MY_IDX = IDX_MAX_W'(CELL_IDX);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins_en)
        begin
            if (cmd.idx == MY_IDX)
                entry_next = cmd.value;
            else if (MY_IDX > cmd.idx)
                entry_next = left;
        end
        else if (cmd.del_en && (MY_IDX >= cmd.idx))
        begin
            // close the gap: take the right neighbour
            entry_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry   = entry_reg;
    assign rd_data = (cmd.rd_en && (cmd.idx == MY_IDX)) ? entry_reg : '0;

endmodule

FILE: hw/rtl/plbu_ctrl.sv
// Request decode, count register and result register of the list buffer.
// Depends on plbu_pkg and positional_list_buffer_unit_assert.svh.
`timescale 1ns / 1ps
`include "positional_list_buffer_unit_assert.svh"

module plbu_ctrl #(
    parameter int CAPACITY = plbu_pkg::CAPACITY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [2:0]                     req_type,
    input  logic [plbu_pkg::DATA_W-1:0]    value,
    input  logic [4:0]                     position,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [1:0]                     status,
    output logic [plbu_pkg::DATA_W-1:0]    read_value,
    output logic [4:0]                     count,
    input  logic [plbu_pkg::DATA_W-1:0]    rd_or,
    output plbu_pkg::plbu_cmd_t            cmd
);
    import plbu_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > 5) ? CNT_W : 5) + 1;

    logic              out_valid_reg;
    logic              out_valid_next;
    status_t           status_reg;
    status_t           status_next;
    logic [DATA_W-1:0] rd_value_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              accept;
    logic              full;
    logic              empty;
    logic [CMP_W-1:0]  cnt_w;
    logic [CMP_W-1:0]  pos_w;
    logic [CMP_W-1:0]  idx_full;
    logic              ins_en;
    logic              del_en;
    logic              rd_en;
    req_t              req;

    assign req_stall = out_valid_reg && rsp_stall;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign cnt_w     = CMP_W'(count_reg);
    assign pos_w     = CMP_W'(position);
    assign req       = req_t'(req_type);

    always_comb
    begin
        status_next = ST_OK;
        ins_en      = 1'b0;
        del_en      = 1'b0;
        rd_en       = 1'b0;
        idx_full    = '0;
        count_next  = count_reg;
        case (req)
            REQ_INS_FIRST, REQ_INS_LAST, REQ_INS_AT:
            begin
                if (full)
                    status_next = ST_FULL;
                else if (req == REQ_INS_FIRST)
                    ins_en = 1'b1;
                else if (req == REQ_INS_LAST)
                begin
                    ins_en   = 1'b1;
                    idx_full = cnt_w;
                end
                else if ((pos_w == '0) || (pos_w > cnt_w + CMP_W'(1)))
                    status_next = ST_BADPOS;
                else
                begin
                    ins_en   = 1'b1;
                    idx_full = pos_w - CMP_W'(1);
                end
                if (ins_en)
                    count_next = count_reg + CNT_W'(1);
            end
            REQ_DEL_FIRST, REQ_DEL_LAST, REQ_DEL_AT:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else if (req == REQ_DEL_FIRST)
                    del_en = 1'b1;
                else if (req == REQ_DEL_LAST)
                begin
                    del_en   = 1'b1;
                    idx_full = cnt_w - CMP_W'(1);
                end
                else if ((pos_w == '0) || (pos_w > cnt_w))
                    status_next = ST_BADPOS;
                else
                begin
                    del_en   = 1'b1;
                    idx_full = pos_w - CMP_W'(1);
                end
                if (del_en)
                    count_next = count_reg - CNT_W'(1);
            end
            REQ_READ:
            begin
                if ((pos_w == '0) || (pos_w > cnt_w))
                    status_next = ST_BADPOS;
                else
                begin
                    rd_en    = 1'b1;
                    idx_full = pos_w - CMP_W'(1);
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    // drive the cells only for an accepted item
    always_comb
    begin
        cmd.ins_en = accept && ins_en;
        cmd.del_en = accept && del_en;
        cmd.rd_en  = accept && rd_en;
        cmd.idx    = IDX_MAX_W'(idx_full);
        cmd.value  = value;
    end

    always_comb
    begin
        if (accept)
            out_valid_next = 1'b1;
        else if (rsp_stall)
            out_valid_next = out_valid_reg;
        else
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg   <= status_next;
            rd_value_reg <= rd_or;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign status     = status_reg;
    assign read_value = rd_value_reg;
    assign count      = 5'(count_reg);

    `PLBU_ASSERT(a_cnt_cap, count_reg <= CNT_W'(CAPACITY))
    `PLBU_ASSERT(a_full_cnt, (out_valid_reg && status_reg == ST_FULL) |-> full)
    `PLBU_ASSERT(a_empty_cnt, (out_valid_reg && status_reg == ST_EMPTY) |-> empty)
    `PLBU_ASSERT_NEXT(a_read_keeps_cnt, accept && req == REQ_READ, $stable(count_reg))

endmodule

FILE: hw/rtl/positional_list_buffer_unit.sv
// Positional list buffer: ordered list held in a chain of shifting cells.
// One request in on req_*, one result out on rsp_*; every request gives a result.
// Latency: a result is valid the cycle after its request is accepted.
// Throughput: one request per cycle while req_stall is low; each cell picks
// hold, load, or shift from a neighbour from its own index compare, so all
// cells of a whole insert or delete update together.
// Stall: req_stall rises only while a result waits and rsp_stall is high;
// a result taken in the same cycle frees the output register for the next item.
// read_value is the entry for a successful read, zero otherwise; count is the
// number of entries held after the request.
// Reset: the list is empty and no result is pending. Entry storage is not
// cleared; only entries below the count are ever read.
// Depends on plbu_pkg, plbu_cell and plbu_ctrl.
`timescale 1ns / 1ps

module positional_list_buffer_unit #(
    parameter int CAPACITY = plbu_pkg::CAPACITY_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [2:0]                     req_type,
    input  logic [plbu_pkg::DATA_W-1:0]    value,
    input  logic [4:0]                     position,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [1:0]                     status,
    output logic [plbu_pkg::DATA_W-1:0]    read_value,
    output logic [4:0]                     count
);
    import plbu_pkg::*;

    plbu_cmd_t         cmd;
    logic [DATA_W-1:0] entry   [CAPACITY];
    logic [DATA_W-1:0] rd_data [CAPACITY];
    logic [DATA_W-1:0] rd_or;

    plbu_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_type   (req_type),
        .value      (value),
        .position   (position),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .status     (status),
        .read_value (read_value),
        .count      (count),
        .rd_or      (rd_or),
        .cmd        (cmd)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] left;
        logic [DATA_W-1:0] right;

        if (i == 0)
        begin : g_first
            assign left = '0;
        end
        else
        begin : g_mid_l
            assign left = entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_mid_r
            assign right = entry[i+1];
        end

        plbu_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk     (clk),
            .cmd     (cmd),
            .left    (left),
            .right   (right),
            .entry   (entry[i]),
            .rd_data (rd_data[i])
        );
    end

    // at most one cell drives a non-zero read value
    always_comb
    begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++)
            rd_or = rd_or | rd_data[k];
    end

endmodule
